[hw/rtl/lea_pkg.sv]
// Shared types, codes and word helpers for the LEA cipher core.
// No dependencies.
`default_nettype none
package lea_pkg;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_ENC  = 2'd1;
    localparam logic [1:0] KIND_DEC  = 2'd2;

    localparam int RC_SHORT = 24;
    localparam int RC_MID   = 28;
    localparam int RC_LONG  = 32;
    localparam int KEYS_PER_ROUND = 6;

    localparam logic [1:0] NR_SHORT = 2'd0;
    localparam logic [1:0] NR_MID   = 2'd1;
    localparam logic [1:0] NR_LONG  = 2'd2;

    typedef logic [31:0] word_t;
    typedef word_t [3:0] block_t;
    typedef word_t [KEYS_PER_ROUND-1:0] rkey_t;

    typedef struct packed {
        logic valid;
        logic dec;
    } ctl_t;

    function automatic word_t rol(input word_t v, input int n);
        rol = (v << n) | (v >> (32 - n));
    endfunction

    function automatic word_t ror(input word_t v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lea_rnd.sv]
// One pipeline stage: a single LEA encryption or decryption round, or a pass-through when act is low.
// Uses lea_pkg.
`default_nettype none
module lea_rnd (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           act,
    input  wire lea_pkg::ctl_t  ctl_in,
    input  wire lea_pkg::rkey_t k,
    input  wire lea_pkg::block_t x,
    output lea_pkg::ctl_t       ctl_reg,
    output lea_pkg::block_t     x_reg
);

    lea_pkg::block_t x_next;
    lea_pkg::block_t enc_x;
    lea_pkg::block_t dec_x;

    always_comb begin
        enc_x[0] = lea_pkg::rol((x[0] ^ k[0]) + (x[1] ^ k[1]), 9);
        enc_x[1] = lea_pkg::ror((x[1] ^ k[2]) + (x[2] ^ k[3]), 5);
        enc_x[2] = lea_pkg::ror((x[2] ^ k[4]) + (x[3] ^ k[5]), 3);
        enc_x[3] = x[0];
        dec_x[0] = x[3];
        dec_x[1] = (lea_pkg::ror(x[0], 9) - (dec_x[0] ^ k[0])) ^ k[1];
        dec_x[2] = (lea_pkg::rol(x[1], 5) - (dec_x[1] ^ k[2])) ^ k[3];
        dec_x[3] = (lea_pkg::rol(x[2], 3) - (dec_x[2] ^ k[4])) ^ k[5];
        if (!act) begin
            x_next = x;
        end else if (ctl_in.dec) begin
            x_next = dec_x;
        end else begin
            x_next = enc_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lea_block_cipher_core.sv]
// LEA cipher core: one 128-bit block per transfer, fully pipelined with one
// round per stage, MAX_ROUNDS stages. An accepted block moves through the stage
// registers to the result port, and a new block can enter every cycle while
// the result port is not stalled; stages past the selected round count pass
// data through. Key-load words write the per-round key registers and are held
// off until no block is in flight. Uses lea_pkg and lea_rnd.
`default_nettype none
module lea_block_cipher_core #(
    parameter int MAX_ROUNDS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [7:0]  s_key_index,
    input  wire logic [31:0] s_key_word,
    input  wire logic [31:0] s_block_word0,
    input  wire logic [31:0] s_block_word1,
    input  wire logic [31:0] s_block_word2,
    input  wire logic [31:0] s_block_word3,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_word0,
    output logic [31:0]      m_result_word1,
    output logic [31:0]      m_result_word2,
    output logic [31:0]      m_result_word3
);

    localparam int N0 = (lea_pkg::RC_SHORT < MAX_ROUNDS) ? lea_pkg::RC_SHORT : MAX_ROUNDS;
    localparam int N1 = (lea_pkg::RC_MID < MAX_ROUNDS) ? lea_pkg::RC_MID : MAX_ROUNDS;
    localparam int N2 = MAX_ROUNDS;
    localparam int KEY_WORDS = lea_pkg::KEYS_PER_ROUND * MAX_ROUNDS;
    localparam int RW = $clog2(MAX_ROUNDS);

    logic [1:0]      nr_sel_reg;
    lea_pkg::rkey_t  key_reg [MAX_ROUNDS];
    lea_pkg::ctl_t   stg_ctl [MAX_ROUNDS+1];
    lea_pkg::block_t stg_x   [MAX_ROUNDS+1];
    logic [MAX_ROUNDS-1:0] busy_vec;
    logic            advance;
    logic            busy;
    logic [17:0]     idx_prod;
    logic [7:0]      ld_round;
    logic [7:0]      ld_word;
    logic            ld_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nr_sel_reg <= lea_pkg::NR_SHORT;
        end else if (cfg_valid) begin
            if (cfg_data <= 6'(lea_pkg::RC_SHORT)) begin
                nr_sel_reg <= lea_pkg::NR_SHORT;
            end else if (cfg_data <= 6'(lea_pkg::RC_MID)) begin
                nr_sel_reg <= lea_pkg::NR_MID;
            end else begin
                nr_sel_reg <= lea_pkg::NR_LONG;
            end
        end
    end

    // index / 6 by reciprocal, exact below 192
    assign idx_prod = 18'(s_key_index) * 18'd171;
    assign ld_round = idx_prod[17:10];
    assign ld_word  = s_key_index - 8'(ld_round * 8'd6);
    assign ld_en    = s_valid && s_ready && (s_kind == lea_pkg::KIND_LOAD)
                      && (s_key_index < 8'(KEY_WORDS));

    always_ff @(posedge aclk) begin
        for (int r = 0; r < MAX_ROUNDS; r++) begin
            for (int w = 0; w < lea_pkg::KEYS_PER_ROUND; w++) begin
                if (ld_en && ld_round == 8'(r) && ld_word == 8'(w)) begin
                    key_reg[r][w] <= s_key_word;
                end
            end
        end
    end

    assign advance = !m_valid || m_ready;
    assign busy    = |busy_vec;
    assign s_ready = advance && !((s_kind == lea_pkg::KIND_LOAD) && busy);

    always_comb begin
        stg_ctl[0].valid = s_valid && s_ready
                           && (s_kind == lea_pkg::KIND_ENC || s_kind == lea_pkg::KIND_DEC);
        stg_ctl[0].dec   = (s_kind == lea_pkg::KIND_DEC);
        stg_x[0] = {s_block_word3, s_block_word2, s_block_word1, s_block_word0};
    end

    for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_rnd
        localparam int R0 = (i < N0) ? N0 - 1 - i : 0;
        localparam int R1 = (i < N1) ? N1 - 1 - i : 0;
        localparam int R2 = (i < N2) ? N2 - 1 - i : 0;
        logic           act;
        logic [RW-1:0]  dec_rnd;
        lea_pkg::rkey_t k;

        assign busy_vec[i] = stg_ctl[i+1].valid;

        always_comb begin
            unique case (nr_sel_reg)
                lea_pkg::NR_SHORT: begin
                    act = (i < N0);
                    dec_rnd = RW'(R0);
                end
                lea_pkg::NR_MID: begin
                    act = (i < N1);
                    dec_rnd = RW'(R1);
                end
                default: begin
                    act = (i < N2);
                    dec_rnd = RW'(R2);
                end
            endcase
            k = stg_ctl[i].dec ? key_reg[dec_rnd] : key_reg[i];
        end

        lea_rnd u_rnd (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (advance),
            .act     (act),
            .ctl_in  (stg_ctl[i]),
            .k       (k),
            .x       (stg_x[i]),
            .ctl_reg (stg_ctl[i+1]),
            .x_reg   (stg_x[i+1])
        );
    end

    assign m_valid        = stg_ctl[MAX_ROUNDS].valid;
    assign m_result_word0 = stg_x[MAX_ROUNDS][0];
    assign m_result_word1 = stg_x[MAX_ROUNDS][1];
    assign m_result_word2 = stg_x[MAX_ROUNDS][2];
    assign m_result_word3 = stg_x[MAX_ROUNDS][3];

endmodule
`default_nettype wire

[hw/rtl/lea_chk.sv]
// Port-level checker for lea_block_cipher_core, bound to the top level.
// Depends on lea_block_cipher_core.
`default_nettype none
module lea_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_result_word0,
    input wire logic [31:0] m_result_word3
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result word dropped");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_word0) && $stable(m_result_word3))
        else $error("result word changed under stall");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready) else $error("input taken during stall");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("input word withdrawn");

endmodule

bind lea_block_cipher_core lea_chk u_lea_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_word0 (m_result_word0),
    .m_result_word3 (m_result_word3)
);
`default_nettype wire
